// ----- design/mme_pkg.sv -----
`default_nettype none

package mme_pkg;

  // store geometry
  localparam int MAX_DIM     = 64;
  localparam int MAX_RESULTS = 64;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int ADDR_W      = $clog2(MAX_DIM * MAX_DIM);

  // field widths
  localparam int ACT_W  = 2;
  localparam int FIELD_IDX_W = 6;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int SUM_W  = 38;
  localparam int CFG_W  = 7;
  localparam int CFG_IDX_W = 2;

  // width of an effective dimension, able to hold MAX_DIM itself
  localparam int EFF_W = (CFG_W > $clog2(MAX_DIM + 1)) ? CFG_W : $clog2(MAX_DIM + 1);

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(64);

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE_A = 2'd0,
    ACT_WRITE_B = 2'd1,
    ACT_ROW     = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_LEN = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [ACT_W-1:0]       action;
    logic [FIELD_IDX_W-1:0] row_index;
    logic [FIELD_IDX_W-1:0] col_index;
    logic signed [ELEM_W-1:0] element;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [FIELD_IDX_W-1:0]  out_col;
    logic                    last;
  } out_item_t;

  // register value limited to a ceiling
  function automatic logic [EFF_W-1:0] clamp_dim(logic [CFG_W-1:0] v, int top);
    logic [EFF_W-1:0] w;
    w = EFF_W'(v);
    if (32'(w) > top) begin
      w = EFF_W'(top);
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- design/matrix_multiply_engine.sv -----
`default_nettype none

// Integer matrix product C = A * B with row-major on-chip stores for A and B
// (MAX_DIM x MAX_DIM signed 16-bit elements each). A write-A or write-B request
// stores one element. A row request for a row below rows_a returns the cols_b
// elements of one row of C in column order, each an exact 38-bit signed sum,
// the final one flagged by last. One multiplier fed by a single read port of
// each store performs one product per cycle while a column is issued; in_stall_o
// stays high until the row is done. The block takes the next request as soon
// as the final result of a row sits in the output register. Elements read
// before they were written give undefined sums. Registers are to be written
// through cfg_we_i only while idle; the block itself does not enforce this.
module matrix_multiply_engine (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire mme_pkg::in_item_t          in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output mme_pkg::out_item_t              out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [mme_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mme_pkg::CFG_W-1:0]  cfg_data_i
);
  import mme_pkg::*;

  state_e state_q, state_d;

  logic [CFG_W-1:0] rows_a_q, inner_len_q, cols_b_q;
  logic [EFF_W-1:0] dim_m, dim_k, dim_n;

  logic [IDX_W-1:0] row_q, l_q, j_q;

  logic accept, req_ok, issue, issue_last, out_free, out_load, col_last, col_start;
  logic we_a, we_b;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;

  logic signed [ELEM_W-1:0] mem_a [MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0] mem_b [MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0] rd_a_q, rd_b_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q;

  logic rd_vld_q, rd_last_q, mul_vld_q, mul_last_q, acc_done_q;
  logic out_vld_q;
  out_item_t out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      inner_len_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        CFG_INNER_LEN: inner_len_q <= cfg_data_i;
        CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective dimensions
  always_comb begin
    dim_m = clamp_dim(rows_a_q, MAX_DIM);
    dim_k = clamp_dim(inner_len_q, MAX_DIM);
    dim_n = clamp_dim(cols_b_q, (MAX_DIM < MAX_RESULTS) ? MAX_DIM : MAX_RESULTS);
  end

  // sequencing conditions
  always_comb begin
    accept     = in_valid_i && (state_q == ST_IDLE);
    req_ok     = accept && (in_data_i.action == ACT_ROW)
                 && (32'(in_data_i.row_index) < 32'(dim_m)) && (dim_n != '0);
    issue_last = (EFF_W'(l_q) == dim_k - EFF_W'(1));
    col_last   = (EFF_W'(j_q) == dim_n - EFF_W'(1));
    out_free   = !out_vld_q || !out_stall_i;
    out_load   = (state_q == ST_DRAIN) && acc_done_q && out_free;
    col_start  = req_ok || (out_load && !col_last);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_ok) begin
          state_d = (dim_k == '0) ? ST_DRAIN : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          if (col_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = (dim_k == '0) ? ST_DRAIN : ST_ISSUE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // state outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    issue      = (state_q == ST_ISSUE);
    we_a       = accept && (in_data_i.action == ACT_WRITE_A)
                 && (32'(in_data_i.row_index) < MAX_DIM)
                 && (32'(in_data_i.col_index) < MAX_DIM);
    we_b       = accept && (in_data_i.action == ACT_WRITE_B)
                 && (32'(in_data_i.row_index) < MAX_DIM)
                 && (32'(in_data_i.col_index) < MAX_DIM);
  end

  // store addresses
  always_comb begin
    waddr   = ADDR_W'(in_data_i.row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(in_data_i.col_index);
    raddr_a = ADDR_W'(row_q) * ADDR_W'(MAX_DIM) + ADDR_W'(l_q);
    raddr_b = ADDR_W'(l_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q);
  end

  // row, inner and column counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      l_q   <= '0;
      j_q   <= '0;
    end else begin
      if (req_ok) begin
        row_q <= IDX_W'(in_data_i.row_index);
        j_q   <= '0;
      end else if (out_load && !col_last) begin
        j_q <= j_q + IDX_W'(1);
      end
      if (col_start) begin
        l_q <= '0;
      end else if (issue) begin
        l_q <= l_q + IDX_W'(1);
      end
    end
  end

  // element stores
  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[waddr] <= in_data_i.element;
    end
    if (issue) begin
      rd_a_q <= mem_a[raddr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[waddr] <= in_data_i.element;
    end
    if (issue) begin
      rd_b_q <= mem_b[raddr_b];
    end
  end

  // shared multiplier
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(rd_a_q) * PROD_W'(rd_b_q);
  end

  // pipeline flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      mul_vld_q  <= 1'b0;
      mul_last_q <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      rd_vld_q   <= issue;
      rd_last_q  <= issue && issue_last;
      mul_vld_q  <= rd_vld_q;
      mul_last_q <= rd_last_q;
      if (col_start) begin
        acc_done_q <= (dim_k == '0);
      end else if (mul_vld_q && mul_last_q) begin
        acc_done_q <= 1'b1;
      end else if (out_load) begin
        acc_done_q <= 1'b0;
      end
    end
  end

  // accumulator
  always_ff @(posedge clk_i) begin
    if (col_start) begin
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.sum     <= acc_q;
      out_q.out_col <= FIELD_IDX_W'(j_q);
      out_q.last    <= col_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- design/mme_checker.sv -----
`default_nettype none

module mme_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire mme_pkg::in_item_t             in_data_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire mme_pkg::out_item_t            out_data_o,
  input wire logic                          cfg_we_i,
  input wire logic [mme_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input wire logic [mme_pkg::CFG_W-1:0]     cfg_data_i
);
  import mme_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // mid-row the block takes no new request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("request taken before row finished");

  // results of a row leave in column order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=>
      !out_valid_o || (out_data_o.out_col == $past(out_data_o.out_col) + 6'd1))
    else $error("result column out of order");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);

`default_nettype wire

// ----- tb/mme_product_checker.sv -----
`timescale 1ns / 100ps

// watches both channels and the register port, predicts every row of C and
// compares each returned element with the oldest prediction
module mme_product_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  mme_pkg::in_item_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  mme_pkg::out_item_t            out_data_i,
  input  logic                          cfg_we_i,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mme_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            mismatch_count_o,
  output int                            pending_o
);
  import mme_pkg::*;

  localparam int PRINT_CAP = 100;

  // shadow copies of both element stores and the dimension registers
  logic signed [ELEM_W-1:0] a_elems [MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0] b_elems [MAX_DIM*MAX_DIM];
  logic [CFG_W-1:0] rows_a_q;
  logic [CFG_W-1:0] inner_len_q;
  logic [CFG_W-1:0] cols_b_q;

  // elements of C still owed by the block, oldest first
  out_item_t c_elements_q [$];
  int errors_seen = 0;

  function automatic int dim_limit(input logic [CFG_W-1:0] v, input int ceiling);
    return (int'(v) > ceiling) ? ceiling : int'(v);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    // keep the log readable when the block is badly broken
    if (errors_seen < PRINT_CAP) begin
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    end
    errors_seen++;
  endtask

  // one row of C = A * B, each element summed exactly from zero
  task automatic predict_c_row(input int row);
    int m;
    int k;
    int n;
    longint acc;
    out_item_t elem;
    m = dim_limit(rows_a_q, MAX_DIM);
    k = dim_limit(inner_len_q, MAX_DIM);
    n = dim_limit(cols_b_q, (MAX_DIM < MAX_RESULTS) ? MAX_DIM : MAX_RESULTS);
    if (row >= m || n == 0) begin
      return;
    end
    for (int j = 0; j < n; j++) begin
      acc = 0;
      for (int l = 0; l < k; l++) begin
        acc += longint'(a_elems[row*MAX_DIM + l]) * longint'(b_elems[l*MAX_DIM + j]);
      end
      elem.sum     = SUM_W'(acc);
      elem.out_col = FIELD_IDX_W'(j);
      elem.last    = (j == n - 1);
      c_elements_q.push_back(elem);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      rows_a_q    = DIM_RESET;
      inner_len_q = DIM_RESET;
      cols_b_q    = DIM_RESET;
      c_elements_q.delete();
      pending_o        <= 0;
      mismatch_count_o <= errors_seen;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_ROWS_A:    rows_a_q    = cfg_data_i;
          CFG_INNER_LEN: inner_len_q = cfg_data_i;
          CFG_COLS_B:    cols_b_q    = cfg_data_i;
          default: ;
        endcase
      end

      // accepted requests
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.action)
          ACT_WRITE_A: a_elems[{in_data_i.row_index, in_data_i.col_index}] = in_data_i.element;
          ACT_WRITE_B: b_elems[{in_data_i.row_index, in_data_i.col_index}] = in_data_i.element;
          ACT_ROW:     predict_c_row(int'(in_data_i.row_index));
          default: ;
        endcase
      end

      // accepted results
      if (out_valid_i && !out_stall_i) begin
        if (c_elements_q.size() == 0) begin
          report_mismatch("result with nothing outstanding, column",
                          longint'(out_data_i.out_col), -1);
        end else begin
          want = c_elements_q.pop_front();
          if (out_data_i.sum !== want.sum) begin
            report_mismatch("sum", longint'(out_data_i.sum), longint'(want.sum));
          end
          if (out_data_i.out_col !== want.out_col) begin
            report_mismatch("out_col", longint'(out_data_i.out_col), longint'(want.out_col));
          end
          if (out_data_i.last !== want.last) begin
            report_mismatch("last", longint'(out_data_i.last), longint'(want.last));
          end
        end
      end

      pending_o        <= c_elements_q.size();
      mismatch_count_o <= errors_seen;
    end
  end

endmodule

// ----- tb/matrix_multiply_engine_tb.sv -----
`timescale 1ns / 100ps

module matrix_multiply_engine_tb;
  import mme_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic      req_valid;
  logic      req_stall;
  in_item_t  req_item;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int mismatches;
  int pending;

  // traffic shaping
  int idle_pct;
  int stall_pct;
  bit hold_go;
  int hold_left   = 0;
  int idle_cycles = 0;
  int sent        = 0;

  // effective dimensions and which store entries hold data
  int eff_m;
  int eff_k;
  int eff_n;
  bit a_set [MAX_DIM][MAX_DIM];
  bit b_set [MAX_DIM][MAX_DIM];

  matrix_multiply_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_item),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  mme_product_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (req_valid),
    .in_stall_i       (req_stall),
    .in_data_i        (req_item),
    .out_valid_i      (res_valid),
    .out_stall_i      (res_stall),
    .out_data_i       (res_item),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: random stalls, or one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_go) begin
      res_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (req_valid && !req_stall) || (res_valid && !res_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_elem();
    case ($urandom_range(7))
      0:       return -32768;
      1:       return 32767;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic int pick_index();
    return $urandom_range(1) ? $urandom_range(63) : $urandom_range(7);
  endfunction

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    idle_pct = sender_pct;
    stall_pct <= receiver_pct;
  endtask

  // one request, held until the block takes it
  task automatic issue(input logic [ACT_W-1:0] act, input int row, input int col,
                       input int value);
    in_item_t item;
    item.action    = act;
    item.row_index = FIELD_IDX_W'(row);
    item.col_index = FIELD_IDX_W'(col);
    item.element   = ELEM_W'(value);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_item  <= item;
    do @(posedge clk_i); while (req_stall);
    if (act != ACT_NONE) begin
      sent++;
    end
  endtask

  task automatic load_a(input int r, input int c, input int v);
    issue(ACT_WRITE_A, r, c, v);
    a_set[r][c] = 1'b1;
  endtask

  task automatic load_b(input int r, input int c, input int v);
    issue(ACT_WRITE_B, r, c, v);
    b_set[r][c] = 1'b1;
  endtask

  // row request, preceded by loads of any operand entry it would read unset
  task automatic ask_row(input int r);
    if (r < eff_m && eff_n > 0) begin
      for (int l = 0; l < eff_k; l++) begin
        if (!a_set[r][l]) begin
          load_a(r, l, pick_elem());
        end
      end
      for (int l = 0; l < eff_k; l++) begin
        for (int j = 0; j < eff_n; j++) begin
          if (!b_set[l][j]) begin
            load_b(l, j, pick_elem());
          end
        end
      end
    end
    issue(ACT_ROW, r, $urandom_range(63), pick_elem());
  endtask

  // wait until every element of C has come back and the block is quiet
  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_dims(input int m, input int k, input int n);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ROWS_A;
    cfg_data <= CFG_W'(m);
    @(posedge clk_i);
    cfg_idx  <= CFG_INNER_LEN;
    cfg_data <= CFG_W'(k);
    @(posedge clk_i);
    cfg_idx  <= CFG_COLS_B;
    cfg_data <= CFG_W'(n);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    eff_m = (m > MAX_DIM) ? MAX_DIM : m;
    eff_k = (k > MAX_DIM) ? MAX_DIM : k;
    eff_n = (n > MAX_DIM) ? MAX_DIM : n;
  endtask

  // mostly row requests on filled operands, with stray loads and unused actions
  task automatic random_phase(input int target, input bit redraw);
    int goal;
    int burst;
    int pick;
    int row;
    goal = sent + target;
    while (sent < goal) begin
      burst = goal;
      if (redraw) begin
        settle();
        set_dims($urandom_range(1, 127), $urandom_range(1, 6), $urandom_range(1, 8));
        burst = sent + 20;
      end
      while (sent < burst && sent < goal) begin
        pick = $urandom_range(99);
        row  = (eff_m == 0 || $urandom_range(3) == 0) ? $urandom_range(63)
                                                      : $urandom_range(eff_m - 1);
        if (pick < 66) begin
          ask_row(row);
        end else if (pick < 80) begin
          load_a(pick_index(), pick_index(), pick_elem());
        end else if (pick < 94) begin
          load_b(pick_index(), pick_index(), pick_elem());
        end else begin
          issue(ACT_NONE, $urandom_range(63), $urandom_range(63), pick_elem());
        end
      end
    end
  endtask

  initial begin
    req_valid <= 1'b0;
    req_item  <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_ROWS_A;
    cfg_data  <= '0;
    hold_go   <= 1'b0;
    set_idling(0, 0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extreme elements, all actions, edge dimensions
    set_idling(11, 11);
    set_dims(3, 2, 3);
    load_a(0, 0, 32767);
    load_a(0, 1, -32768);
    load_b(0, 0, 32767);
    load_b(1, 0, -32768);
    load_b(0, 1, -32768);
    load_b(1, 1, -32768);
    // stored even though outside the current dimensions
    load_a(63, 63, -32768);
    load_b(63, 63, 32767);
    issue(ACT_NONE, 63, 63, -1);
    ask_row(0);
    ask_row(2);
    // rows at and past rows_a give nothing back
    ask_row(3);
    ask_row(63);
    // zero inner length: every sum is zero
    settle();
    set_dims(3, 0, 3);
    ask_row(1);
    // zero rows or zero columns: no results at all
    settle();
    set_dims(0, 2, 3);
    ask_row(0);
    settle();
    set_dims(3, 2, 0);
    ask_row(0);

    // full inner length, oversized row count, largest sums of both signs
    settle();
    set_idling(0, 0);
    set_dims(127, 64, 1);
    for (int l = 0; l < MAX_DIM; l++) begin
      load_a(0, l, -32768);
      load_b(l, 0, -32768);
    end
    ask_row(0);
    for (int l = 0; l < MAX_DIM; l++) begin
      load_a(63, l, 32767);
    end
    ask_row(63);

    // oversized column count: 64 results per row request
    settle();
    set_idling(62, 0);
    set_dims(2, 1, 127);
    random_phase(20, 1'b0);

    settle();
    set_idling(0, 62);
    random_phase(20, 1'b1);

    settle();
    set_idling(11, 11);
    random_phase(20, 1'b1);

    // long receiver hold-off while requests keep coming
    settle();
    set_idling(0, 0);
    set_dims(8, 4, 8);
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    random_phase(20, 1'b0);

    settle();
    set_idling(62, 0);
    random_phase(20, 1'b1);

    settle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
